// ----- rtl/rpq_pkg.sv -----
// ----------------------------------------------------------------------------
// rpq_pkg
// Types, sizes and codes shared by the ready queue modules.
// ----------------------------------------------------------------------------
package rpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 8;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 4;
  localparam int IN_PRIO_W = 8;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_DUP  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_HEAD
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   taken_id;
    logic              taken_valid;
    logic [ID_W-1:0]   head_id;
    logic              is_empty;
    logic [CNT_W-1:0]  occupancy;
  } result_t;

  // keep the low PRIO_BITS of the incoming priority, zero fill above it
  function automatic logic [PRIO_BITS-1:0] mask_prio(input logic [IN_PRIO_W-1:0] p);
    logic [PRIO_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < PRIO_BITS; i++) begin
      if (i < IN_PRIO_W) begin
        r[i] = p[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/rpq_store.sv -----
// ----------------------------------------------------------------------------
// rpq_store
// Entry register file: one write port, one read port, head at entry zero.
// ----------------------------------------------------------------------------
module rpq_store (
  input  logic              clk,
  input  rpq_pkg::mem_req_t req,
  output rpq_pkg::entry_t   rd_entry
);

  rpq_pkg::entry_t mem_r [rpq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  assign rd_entry = mem_r[req.raddr];

endmodule

// ----- rtl/rpq_seq.sv -----
// ----------------------------------------------------------------------------
// rpq_seq
// Sequencer: scans the queue one entry a cycle through a single id/priority
// comparator, then opens or closes a gap one entry a cycle.
// ----------------------------------------------------------------------------
module rpq_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rpq_pkg::KIND_W-1:0]      kind,
  input  logic [rpq_pkg::ID_W-1:0]        slot_id,
  input  logic [rpq_pkg::IN_PRIO_W-1:0]   prio,
  input  logic                            res_free,
  output rpq_pkg::mem_req_t               mem_req,
  input  rpq_pkg::entry_t                 rd_entry,
  output logic                            res_load,
  output rpq_pkg::result_t                res,
  output logic                            busy
);

  rpq_pkg::state_t state_r, state_nxt;

  logic [rpq_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rpq_pkg::CNT_W-1:0]     fill_r, fill_nxt;
  logic [rpq_pkg::CNT_W-1:0]     ipos_r, ipos_nxt;
  logic [rpq_pkg::IDX_W-1:0]     fpos_r, fpos_nxt;
  logic [rpq_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [rpq_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [rpq_pkg::PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                          found_r, found_nxt;
  logic [rpq_pkg::ID_W-1:0]      taken_r, taken_nxt;
  logic                          taken_vld_r, taken_vld_nxt;
  logic [rpq_pkg::STAT_W-1:0]    status_r, status_nxt;

  logic [rpq_pkg::CNT_W-1:0] cnt_inc;
  logic [rpq_pkg::CNT_W-1:0] cnt_dec;
  logic [rpq_pkg::IDX_W-1:0] idx;
  logic                      scan_end;
  logic                      full;
  logic                      id_match;
  logic                      prio_ge;

  assign cnt_inc  = cnt_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;
  assign idx      = cnt_r[rpq_pkg::IDX_W-1:0];
  assign scan_end = (cnt_r == fill_r);
  assign full     = (fill_r == rpq_pkg::CNT_W'(rpq_pkg::QUEUE_DEPTH));

  // the shared compare unit
  assign id_match = (kind_r == rpq_pkg::KIND_POP) ? (cnt_r == '0) : (rd_entry.id == id_r);
  assign prio_ge  = (rd_entry.prio >= prio_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpq_pkg::S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    ipos_r      <= ipos_nxt;
    fpos_r      <= fpos_nxt;
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    found_r     <= found_nxt;
    taken_r     <= taken_nxt;
    taken_vld_r <= taken_vld_nxt;
    status_r    <= status_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = rpq_pkg::S_SCAN;
        end
      end
      rpq_pkg::S_SCAN: begin
        if (scan_end) begin
          case (kind_r)
            rpq_pkg::KIND_INSERT: begin
              state_nxt = (found_r || full) ? rpq_pkg::S_HEAD : rpq_pkg::S_SHUP;
            end
            rpq_pkg::KIND_POP, rpq_pkg::KIND_REMOVE: begin
              state_nxt = found_r ? rpq_pkg::S_SHDN : rpq_pkg::S_HEAD;
            end
            default: begin
              state_nxt = rpq_pkg::S_HEAD;
            end
          endcase
        end
      end
      rpq_pkg::S_SHUP: begin
        if (cnt_r <= ipos_r) begin
          state_nxt = rpq_pkg::S_HEAD;
        end
      end
      rpq_pkg::S_SHDN: begin
        if (cnt_inc >= fill_r) begin
          state_nxt = rpq_pkg::S_HEAD;
        end
      end
      rpq_pkg::S_HEAD: begin
        if (res_free) begin
          state_nxt = rpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rpq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    ipos_nxt      = ipos_r;
    fpos_nxt      = fpos_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    found_nxt     = found_r;
    taken_nxt     = taken_r;
    taken_vld_nxt = taken_vld_r;
    status_nxt    = status_r;
    mem_req       = '0;
    mem_req.raddr = idx;
    res_load      = 1'b0;
    busy          = (state_r != rpq_pkg::S_IDLE);

    res.status      = status_r;
    res.taken_id    = taken_vld_r ? taken_r : '0;
    res.taken_valid = taken_vld_r;
    res.head_id     = (fill_r == '0) ? '0 : rd_entry.id;
    res.is_empty    = (fill_r == '0);
    res.occupancy   = fill_r;

    case (state_r)
      rpq_pkg::S_IDLE: begin
        if (start) begin
          kind_nxt      = kind;
          id_nxt        = slot_id;
          prio_nxt      = rpq_pkg::mask_prio(prio);
          cnt_nxt       = '0;
          ipos_nxt      = '0;
          found_nxt     = 1'b0;
          taken_nxt     = '0;
          taken_vld_nxt = 1'b0;
          status_nxt    = rpq_pkg::STAT_OK;
        end
      end
      rpq_pkg::S_SCAN: begin
        if (!scan_end) begin
          if (id_match && !found_r) begin
            found_nxt = 1'b1;
            fpos_nxt  = idx;
            taken_nxt = rd_entry.id;
          end
          // insert goes after the last entry whose priority is not lower
          if (prio_ge) begin
            ipos_nxt = cnt_inc;
          end
          cnt_nxt = cnt_inc;
        end else begin
          case (kind_r)
            rpq_pkg::KIND_INSERT: begin
              if (found_r) begin
                status_nxt = rpq_pkg::STAT_DUP;
              end else if (full) begin
                status_nxt = rpq_pkg::STAT_MISS;
              end else begin
                cnt_nxt = fill_r;
              end
            end
            rpq_pkg::KIND_POP, rpq_pkg::KIND_REMOVE: begin
              if (found_r) begin
                taken_vld_nxt = 1'b1;
                cnt_nxt       = rpq_pkg::CNT_W'(fpos_r);
              end else begin
                status_nxt = rpq_pkg::STAT_MISS;
              end
            end
            default: begin
              status_nxt = rpq_pkg::STAT_OK;
            end
          endcase
        end
      end
      rpq_pkg::S_SHUP: begin
        mem_req.raddr = cnt_dec[rpq_pkg::IDX_W-1:0];
        mem_req.we    = 1'b1;
        if (cnt_r > ipos_r) begin
          mem_req.waddr = idx;
          mem_req.wdata = rd_entry;
          cnt_nxt       = cnt_dec;
        end else begin
          mem_req.waddr      = ipos_r[rpq_pkg::IDX_W-1:0];
          mem_req.wdata.id   = id_r;
          mem_req.wdata.prio = prio_r;
          fill_nxt           = fill_r + 1'b1;
        end
      end
      rpq_pkg::S_SHDN: begin
        mem_req.raddr = cnt_inc[rpq_pkg::IDX_W-1:0];
        if (cnt_inc < fill_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx;
          mem_req.wdata = rd_entry;
          cnt_nxt       = cnt_inc;
        end else begin
          fill_nxt = fill_r - 1'b1;
        end
      end
      rpq_pkg::S_HEAD: begin
        mem_req.raddr = '0;
        res_load      = res_free;
      end
      default: begin
        mem_req.raddr = idx;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= rpq_pkg::CNT_W'(rpq_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |->
      (fill_r == $past(fill_r) + 1'b1) || (fill_r == $past(fill_r) - 1'b1))
    else $error("fill moved by more than one entry");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpq_pkg::S_IDLE && start) |=> (state_r == rpq_pkg::S_SCAN))
    else $error("accepted word did not start a scan");

  a_load_head: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (state_r == rpq_pkg::S_HEAD))
    else $error("result written outside head step");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (rpq_pkg::CNT_W'(mem_req.waddr) <= fill_r))
    else $error("entry write past queue tail");
`endif

endmodule

// ----- rtl/priority_ordered_ready_queue_unit.sv -----
// ----------------------------------------------------------------------------
// priority_ordered_ready_queue_unit
// Ready queue of slot ids in descending priority, ties first in first out.
//
//   channel  | direction | handshake         | payload
//   in_      | input     | in_valid/in_stall | kind, slot_id, prio
//   out_     | output    | out_valid/out_stall | status, taken_id, taken_valid,
//            |           |                   |   head_id, is_empty, occupancy
//
// A word is accepted, then scanned entry by entry through one shared
// id/priority comparator, then shifted one entry a cycle where the queue
// changes, and last the head entry is read.
// Synchronous active-low reset empties the queue; entry storage is not cleared.
// in_stall is high while a word is in work and during reset; a held result
// waits in the output register and only the head read step waits on out_stall.
// ----------------------------------------------------------------------------
module priority_ordered_ready_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpq_pkg::KIND_W-1:0]    in_kind,
  input  logic [rpq_pkg::ID_W-1:0]      in_slot_id,
  input  logic [rpq_pkg::IN_PRIO_W-1:0] in_prio,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpq_pkg::STAT_W-1:0]    out_status,
  output logic [rpq_pkg::ID_W-1:0]      out_taken_id,
  output logic                          out_taken_valid,
  output logic [rpq_pkg::ID_W-1:0]      out_head_id,
  output logic                          out_is_empty,
  output logic [rpq_pkg::CNT_W-1:0]     out_occupancy
);

  rpq_pkg::mem_req_t mem_req;
  rpq_pkg::entry_t   rd_entry;
  rpq_pkg::result_t  res;
  rpq_pkg::result_t  res_r;
  logic              res_load;
  logic              res_free;
  logic              busy;
  logic              out_valid_r;

  assign in_stall = busy || !rst_n;
  assign res_free = !out_valid_r || !out_stall;

  rpq_store u_store (
    .clk      (clk),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  rpq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid),
    .kind     (in_kind),
    .slot_id  (in_slot_id),
    .prio     (in_prio),
    .res_free (res_free),
    .mem_req  (mem_req),
    .rd_entry (rd_entry),
    .res_load (res_load),
    .res      (res),
    .busy     (busy)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_taken_id    = res_r.taken_id;
  assign out_taken_valid = res_r.taken_valid;
  assign out_head_id     = res_r.head_id;
  assign out_is_empty    = res_r.is_empty;
  assign out_occupancy   = res_r.occupancy;

endmodule
